/* design/p3drpg_pkg.sv */
// Shared types and constants for the pseudo-3D road pixel generator.
// No dependencies; used by every other design file.
`default_nettype none

package p3drpg_pkg;

    localparam int COORD_W    = 10;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int SCREEN_WIDTH = 320;
    localparam logic signed [12:0] SCREEN_HALF = 13'(SCREEN_WIDTH / 2);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_ROW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROAD_HALF_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_POSITION = 3'd4;

    // Ground rows start 7 rows below the horizon (depth above the sky cutoff)
    localparam logic [9:0]  SKY_ROWS    = 10'd7;
    localparam logic [10:0] DEPTH_BIAS  = 11'd8;
    localparam logic [3:0]  DIV_TOP     = 4'd14;
    localparam logic [10:0] SKY_OFFSET  = 11'd32;
    localparam logic [4:0]  FRAME_DELAY = 5'd21;

    localparam logic [19:0] BAND_LO  = 20'd200;
    localparam logic [19:0] BAND_HI  = 20'd220;
    localparam logic [19:0] CENTER_W = 20'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CURVE,
        ST_LAT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic curve_step;
        logic lat_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic sky;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* design/p3drpg_if.sv */
// Channel interfaces: pixel request, color result, configuration write.
// Depends on p3drpg_pkg for field widths.
`default_nettype none

interface p3drpg_pix_if;
    logic                            valid;
    logic                            ready;
    logic [p3drpg_pkg::COORD_W-1:0]  column;
    logic [p3drpg_pkg::COORD_W-1:0]  row;
    logic                            frame_end;
    modport source (output valid, column, row, frame_end, input ready);
    modport sink (input valid, column, row, frame_end, output ready);
endinterface

interface p3drpg_rgb_if;
    logic                           valid;
    logic                           ready;
    logic [p3drpg_pkg::CHAN_W-1:0]  red;
    logic [p3drpg_pkg::CHAN_W-1:0]  green;
    logic [p3drpg_pkg::CHAN_W-1:0]  blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

interface p3drpg_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [p3drpg_pkg::CFG_IDX_W-1:0]   index;
    logic [p3drpg_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/p3drpg_ctrl.sv */
// Sequencing state machine: accept, divide, curve, lateral, finish.
// Depends on p3drpg_pkg (state_t, dp_cmd_t, dp_status_t).
`default_nettype none

module p3drpg_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire p3drpg_pkg::dp_status_t status,
    output p3drpg_pkg::dp_cmd_t         cmd
);

    p3drpg_pkg::state_t state_reg;
    p3drpg_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= p3drpg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            p3drpg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = p3drpg_pkg::ST_DIV;
                end
            end
            p3drpg_pkg::ST_DIV:
            begin
                if (status.sky)
                begin
                    state_next = p3drpg_pkg::ST_FIN;
                end
                else if (status.div_last)
                begin
                    state_next = p3drpg_pkg::ST_CURVE;
                end
            end
            p3drpg_pkg::ST_CURVE: state_next = p3drpg_pkg::ST_LAT;
            p3drpg_pkg::ST_LAT:   state_next = p3drpg_pkg::ST_FIN;
            p3drpg_pkg::ST_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = p3drpg_pkg::ST_IDLE;
                end
            end
            default: state_next = p3drpg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            p3drpg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            p3drpg_pkg::ST_DIV:   cmd.div_step   = !status.sky;
            p3drpg_pkg::ST_CURVE: cmd.curve_step = 1'b1;
            p3drpg_pkg::ST_LAT:   cmd.lat_step   = 1'b1;
            p3drpg_pkg::ST_FIN:   cmd.finish     = status.out_free;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/p3drpg_dp.sv */
// Datapath: config registers, frame state, radix-2 depth divider,
// curve and lateral multipliers, color select and output register.
// Depends on p3drpg_pkg.
`default_nettype none

module p3drpg_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire p3drpg_pkg::dp_cmd_t                  cmd,
    output p3drpg_pkg::dp_status_t                    status,
    input  wire logic [p3drpg_pkg::COORD_W-1:0]       column,
    input  wire logic [p3drpg_pkg::COORD_W-1:0]       row,
    input  wire logic                                 frame_end,
    input  wire logic                                 cfg_write,
    input  wire logic [p3drpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [p3drpg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [p3drpg_pkg::CHAN_W-1:0]             red,
    output logic [p3drpg_pkg::CHAN_W-1:0]             green,
    output logic [p3drpg_pkg::CHAN_W-1:0]             blue,
    output logic                                      out_valid,
    input  wire logic                                 out_ready
);

    // configuration
    logic [9:0]        horizon_reg;
    logic [9:0]        half_width_reg;
    logic [6:0]        turn_limit_reg;
    logic [7:0]        fwd_step_reg;
    logic signed [9:0] lat_pos_reg;

    // frame state
    logic signed [7:0] turn_reg;
    logic              rising_reg;
    logic [4:0]        fcount_reg;
    logic [7:0]        scroll_reg;

    // per-pixel working registers
    logic [9:0]         col_reg;
    logic [9:0]         row_reg;
    logic               fend_reg;
    logic               sky_reg;
    logic [10:0]        dvs_reg;
    logic [10:0]        rem_reg;
    logic [10:0]        q_reg;
    logic [3:0]         cnt_reg;
    logic signed [10:0] curve_reg;
    logic [25:0]        u_reg;

    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic       out_valid_reg;

    logic [10:0]        row_diff;
    logic               sky_in;
    logic [10:0]        offs_in;
    logic [11:0]        rem_sh;
    logic               fits;
    logic [10:0]        rem_next;
    logic [10:0]        q_next;
    logic signed [11:0] depth_s;
    logic signed [19:0] curve_prod;
    logic signed [10:0] curve_next;
    logic signed [12:0] lat_x;
    logic signed [24:0] u_prod;
    logic [25:0]        lat_term;
    logic [25:0]        turn_term;
    logic [25:0]        u_next;
    logic [25:0]        u_abs;
    logic [19:0]        lat_dist;
    logic [7:0]         v;
    logic               band;
    logic               road;
    logic [10:0]        row_m;
    logic [7:0]         sky_level;
    logic [7:0]         red_next;
    logic [7:0]         green_next;
    logic [7:0]         blue_next;

    logic [7:0]        scroll_next;
    logic [4:0]        fcount_next;
    logic              step_up;
    logic signed [8:0] t9;
    logic signed [8:0] lim9;
    logic signed [8:0] nlim9;
    logic [7:0]        turn_next;
    logic              rising_next;

    // request decode
    assign row_diff = {1'b0, row} - {1'b0, horizon_reg};
    assign sky_in   = row_diff[10] || (row_diff[9:0] < p3drpg_pkg::SKY_ROWS);
    assign offs_in  = {1'b0, row_diff[9:0]} + p3drpg_pkg::DEPTH_BIAS;

    // 16384 / offset, one quotient bit per cycle
    assign rem_sh   = {rem_reg, cnt_reg == p3drpg_pkg::DIV_TOP};
    assign fits     = rem_sh >= {1'b0, dvs_reg};
    assign rem_next = fits ? 11'(rem_sh - {1'b0, dvs_reg}) : rem_sh[10:0];
    assign q_next   = {q_reg[9:0], fits};

    assign depth_s    = signed'({1'b0, q_reg});
    assign curve_prod = depth_s * turn_reg;
    assign curve_next = curve_prod[19:9];

    assign lat_x     = signed'({3'b000, col_reg}) - p3drpg_pkg::SCREEN_HALF
                       + 13'(curve_reg);
    assign u_prod    = lat_x * depth_s;
    assign lat_term  = {{10{lat_pos_reg[9]}}, lat_pos_reg, 6'b000000};
    assign turn_term = {{10{turn_reg[7]}}, turn_reg, 8'h00};
    assign u_next    = lat_term + 26'(u_prod) - turn_term;

    assign u_abs    = u_reg[25] ? (~u_reg + 26'd1) : u_reg;
    assign lat_dist = u_abs[25:6];
    assign v        = scroll_reg + q_reg[7:0];
    assign band     = ((lat_dist > p3drpg_pkg::BAND_LO && lat_dist < p3drpg_pkg::BAND_HI)
                       || lat_dist < p3drpg_pkg::CENTER_W) && v[7];
    assign road     = lat_dist < {10'b0, half_width_reg};

    assign row_m     = {1'b0, row_reg} - p3drpg_pkg::SKY_OFFSET;
    assign sky_level = row_m[10] ? 8'd0 : ((row_m[9:8] != 2'b00) ? 8'd255 : row_m[7:0]);

    always_comb
    begin
        if (sky_reg)
        begin
            red_next   = sky_level;
            green_next = sky_level;
            blue_next  = 8'd255;
        end
        else if (band)
        begin
            red_next   = 8'd200;
            green_next = 8'd200;
            blue_next  = 8'd200;
        end
        else if (road)
        begin
            red_next   = v[6] ? 8'd4 : 8'd7;
            green_next = 8'd7;
            blue_next  = v[6] ? 8'd5 : 8'd6;
        end
        else
        begin
            red_next   = v[6] ? 8'd21 : 8'd26;
            green_next = v[6] ? 8'd80 : 8'd60;
            blue_next  = 8'd0;
        end
    end

    // frame-end update of scroll and turn swing
    assign scroll_next = scroll_reg + fwd_step_reg;
    assign fcount_next = (fcount_reg < p3drpg_pkg::FRAME_DELAY) ? fcount_reg + 5'd1
                                                                : fcount_reg;
    assign step_up = (fcount_next == p3drpg_pkg::FRAME_DELAY) ? rising_reg : !rising_reg;
    assign t9      = {turn_reg[7], turn_reg} + (step_up ? 9'd1 : 9'h1FF);
    assign lim9    = {2'b00, turn_limit_reg};
    assign nlim9   = -lim9;

    always_comb
    begin
        turn_next   = t9[7:0];
        rising_next = rising_reg;
        if (t9 > lim9)
        begin
            turn_next   = lim9[7:0];
            rising_next = 1'b0;
        end
        else if (t9 < nlim9)
        begin
            turn_next   = nlim9[7:0];
            rising_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg    <= 10'd120;
            half_width_reg <= 10'd250;
            turn_limit_reg <= 7'd64;
            fwd_step_reg   <= 8'd32;
            lat_pos_reg    <= '0;
            turn_reg       <= '0;
            rising_reg     <= 1'b1;
            fcount_reg     <= '0;
            scroll_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    p3drpg_pkg::CFG_HORIZON_ROW:      horizon_reg    <= cfg_data;
                    p3drpg_pkg::CFG_ROAD_HALF_WIDTH:  half_width_reg <= cfg_data;
                    p3drpg_pkg::CFG_TURN_LIMIT:       turn_limit_reg <= cfg_data[6:0];
                    p3drpg_pkg::CFG_FORWARD_STEP:     fwd_step_reg   <= cfg_data[7:0];
                    p3drpg_pkg::CFG_LATERAL_POSITION: lat_pos_reg    <= signed'(cfg_data);
                    default:
                    begin
                        horizon_reg <= horizon_reg;
                    end
                endcase
            end
            if (cmd.finish && fend_reg)
            begin
                scroll_reg <= scroll_next;
                fcount_reg <= fcount_next;
                turn_reg   <= signed'(turn_next);
                rising_reg <= rising_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg  <= column;
            row_reg  <= row;
            fend_reg <= frame_end;
            sky_reg  <= sky_in;
            dvs_reg  <= offs_in;
            rem_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= p3drpg_pkg::DIV_TOP;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            cnt_reg <= cnt_reg - 4'd1;
        end
        if (cmd.curve_step)
        begin
            curve_reg <= curve_next;
        end
        if (cmd.lat_step)
        begin
            u_reg <= u_next;
        end
        if (cmd.finish)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign status.sky      = sky_reg;
    assign status.div_last = cnt_reg == 4'd0;
    assign status.out_free = !out_valid_reg || out_ready;

    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* design/pseudo_3d_road_pixel_generator.sv */
// Top level of the pseudo-3D road pixel generator.
// Depends on p3drpg_pkg, p3drpg_if, p3drpg_ctrl and p3drpg_dp.
`default_nettype none

// One pixel request at a time. A ground pixel passes through acceptance, the
// one-quotient-bit-per-cycle depth divider, the curve multiply, the lateral
// multiply and the color select before the next request can be taken; a sky
// pixel goes from the divider state straight to the color select.
// The color result sits in an output register, so a new request is accepted
// while the previous color waits to be taken; the finish step waits only if
// that register is still full. Frame-end requests advance scroll and turn
// when their color is produced. Configuration writes are always ready and
// must be issued only while the block is idle.

module pseudo_3d_road_pixel_generator (
    input  wire logic    clk,
    input  wire logic    rst_n,
    p3drpg_pix_if.sink   pixel,
    p3drpg_rgb_if.source color,
    p3drpg_cfg_if.sink   cfg
);

    p3drpg_pkg::dp_cmd_t    cmd;
    p3drpg_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    p3drpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (pixel.ready),
        .status   (status),
        .cmd      (cmd)
    );

    p3drpg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .column    (pixel.column),
        .row       (pixel.row),
        .frame_end (pixel.frame_end),
        .cfg_write (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .red       (color.red),
        .green     (color.green),
        .blue      (color.blue),
        .out_valid (color.valid),
        .out_ready (color.ready)
    );

endmodule

`default_nettype wire

/* design/p3drpg_checker.sv */
// Port-level checks for the pseudo-3D road pixel generator, bound to the top.
// Depends on p3drpg_pkg widths.
`default_nettype none

module p3drpg_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            pix_valid,
    input wire logic                            pix_ready,
    input wire logic                            rgb_valid,
    input wire logic                            rgb_ready,
    input wire logic [p3drpg_pkg::CHAN_W-1:0]   red,
    input wire logic [p3drpg_pkg::CHAN_W-1:0]   green,
    input wire logic [p3drpg_pkg::CHAN_W-1:0]   blue
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=> rgb_valid)
        else $error("color dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=> $stable(red) && $stable(green) && $stable(blue))
        else $error("color changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready |=> !pix_ready ##1 !pix_ready)
        else $error("request accepted too soon after previous one");

    a_palette: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |->
            (blue == 8'd255 && red == green)
            || (red == 8'd200 && green == 8'd200 && blue == 8'd200)
            || (red == 8'd4 && green == 8'd7 && blue == 8'd5)
            || (red == 8'd7 && green == 8'd7 && blue == 8'd6)
            || (red == 8'd21 && green == 8'd80 && blue == 8'd0)
            || (red == 8'd26 && green == 8'd60 && blue == 8'd0))
        else $error("color outside the scene palette");

endmodule

bind pseudo_3d_road_pixel_generator p3drpg_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pixel.valid),
    .pix_ready (pixel.ready),
    .rgb_valid (color.valid),
    .rgb_ready (color.ready),
    .red       (color.red),
    .green     (color.green),
    .blue      (color.blue)
);

`default_nettype wire

/* tb/sv/p3drpg_road_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the pseudo-3D road pixel generator. It follows configuration writes,
// predicts the color of every accepted pixel request and checks each accepted color.
// Depends on p3drpg_pkg for widths, register indexes and the screen width.

module p3drpg_road_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    input  logic                                pix_ready,
    input  logic [p3drpg_pkg::COORD_W-1:0]      pix_column,
    input  logic [p3drpg_pkg::COORD_W-1:0]      pix_row,
    input  logic                                pix_frame_end,
    input  logic                                rgb_valid,
    input  logic                                rgb_ready,
    input  logic [p3drpg_pkg::CHAN_W-1:0]       rgb_red,
    input  logic [p3drpg_pkg::CHAN_W-1:0]       rgb_green,
    input  logic [p3drpg_pkg::CHAN_W-1:0]       rgb_blue,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [p3drpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [p3drpg_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                  errors,
    output int                                  pending
);
    import p3drpg_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    logic [COORD_W-1:0]    horizon;
    logic [COORD_W-1:0]    half_width;
    logic [6:0]            swing_limit;
    logic [7:0]            scroll_step;
    logic signed [9:0]     viewer_x;

    logic signed [7:0]     turn;
    logic                  turn_up;
    logic [4:0]            frames_seen;
    logic [7:0]            scroll;

    rgb_t                  expected_colors[$];
    int                    fail_count;

    function automatic rgb_t road_color(input logic [COORD_W-1:0] col,
                                        input logic [COORD_W-1:0] row);
        longint offs;
        longint depth;
        longint curve;
        longint u;
        longint lat_dist;
        longint shade;
        logic [7:0] v;
        logic sky;
        logic band;
        rgb_t c;
        sky = 1'b1;
        depth = 0;
        if (row >= horizon) begin
            offs = longint'(row) - longint'(horizon) + 8;
            depth = 16384 / offs;
            sky = (depth >>> 4) > 70;
        end
        if (sky) begin
            shade = longint'(row) - 32;
            if (shade < 0)
                shade = 0;
            if (shade > 255)
                shade = 255;
            c.red = shade[7:0];
            c.green = shade[7:0];
            c.blue = 8'd255;
        end else begin
            // arithmetic shift gives the floor of the signed division by 512
            curve = (depth * longint'(turn)) >>> 9;
            u = longint'(viewer_x) * 64
              + (longint'(col) - SCREEN_WIDTH / 2 + curve) * depth
              - longint'(turn) * 256;
            lat_dist = (u < 0 ? -u : u) >>> 6;
            v = scroll + depth[7:0];
            band = ((lat_dist > 200 && lat_dist < 220) || lat_dist < 10) && v[7];
            if (band)
                c = rgb_t'{8'd200, 8'd200, 8'd200};
            else if (lat_dist < longint'(half_width))
                c = v[6] ? rgb_t'{8'd4, 8'd7, 8'd5} : rgb_t'{8'd7, 8'd7, 8'd6};
            else
                c = v[6] ? rgb_t'{8'd21, 8'd80, 8'd0} : rgb_t'{8'd26, 8'd60, 8'd0};
        end
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        rgb_t want;
        int next_turn;
        if (!rst_n)
        begin
            horizon = 10'd120;
            half_width = 10'd250;
            swing_limit = 7'd64;
            scroll_step = 8'd32;
            viewer_x = '0;
            turn = '0;
            turn_up = 1'b1;
            frames_seen = '0;
            scroll = '0;
            expected_colors.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HORIZON_ROW:      horizon = cfg_data;
                    CFG_ROAD_HALF_WIDTH:  half_width = cfg_data;
                    CFG_TURN_LIMIT:       swing_limit = cfg_data[6:0];
                    CFG_FORWARD_STEP:     scroll_step = cfg_data[7:0];
                    CFG_LATERAL_POSITION: viewer_x = signed'(cfg_data);
                    default: ;
                endcase
            end

            if (rgb_valid && rgb_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: color %0d,%0d,%0d with no pending request",
                             $time, rgb_red, rgb_green, rgb_blue);
                    fail_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (rgb_red !== want.red)
                    begin
                        $display("%0t: red mismatch: expected %0d, actual %0d",
                                 $time, want.red, rgb_red);
                        fail_count++;
                    end
                    if (rgb_green !== want.green)
                    begin
                        $display("%0t: green mismatch: expected %0d, actual %0d",
                                 $time, want.green, rgb_green);
                        fail_count++;
                    end
                    if (rgb_blue !== want.blue)
                    begin
                        $display("%0t: blue mismatch: expected %0d, actual %0d",
                                 $time, want.blue, rgb_blue);
                        fail_count++;
                    end
                end
            end

            if (pix_valid && pix_ready)
            begin
                expected_colors.push_back(road_color(pix_column, pix_row));
                if (pix_frame_end)
                begin
                    scroll = scroll + scroll_step;
                    if (frames_seen < 5'd21)
                        frames_seen = frames_seen + 5'd1;
                    // moves against its direction until the start delay has passed
                    if (frames_seen > 5'd20)
                        next_turn = int'(turn) + (turn_up ? 1 : -1);
                    else
                        next_turn = int'(turn) - (turn_up ? 1 : -1);
                    if (next_turn > int'(swing_limit))
                    begin
                        next_turn = int'(swing_limit);
                        turn_up = 1'b0;
                    end
                    else if (next_turn < -int'(swing_limit))
                    begin
                        next_turn = -int'(swing_limit);
                        turn_up = 1'b1;
                    end
                    turn = 8'(next_turn);
                end
            end
        end
        errors <= fail_count;
        pending <= expected_colors.size();
    end

endmodule

/* tb/sv/pseudo_3d_road_pixel_generator_tb.sv */
`timescale 1ns / 1ps
// Testbench top: drives pixel requests and configuration writes with random idling
// and back-pressure, and gives the verdict. Depends on p3drpg_pkg, p3drpg_if,
// the block and p3drpg_road_checker.

module pseudo_3d_road_pixel_generator_tb;
    import p3drpg_pkg::*;

    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int LATENCY = 19;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    p3drpg_pix_if pixel();
    p3drpg_rgb_if color();
    p3drpg_cfg_if cfg();

    int errors;
    int pending;
    int cycles = 0;
    int hold_cycles = 0;
    logic src_burst = 1'b0;
    logic dst_burst = 1'b0;
    logic [COORD_W-1:0] horizon_now = 10'd120;

    pseudo_3d_road_pixel_generator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel),
        .color (color),
        .cfg   (cfg)
    );

    p3drpg_road_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pixel.valid),
        .pix_ready     (pixel.ready),
        .pix_column    (pixel.column),
        .pix_row       (pixel.row),
        .pix_frame_end (pixel.frame_end),
        .rgb_valid     (color.valid),
        .rgb_ready     (color.ready),
        .rgb_red       (color.red),
        .rgb_green     (color.green),
        .rgb_blue      (color.blue),
        .cfg_valid     (cfg.valid),
        .cfg_ready     (cfg.ready),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .errors        (errors),
        .pending       (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap(input logic burst);
        return burst ? 0 : int'($urandom_range(0, 18));
    endfunction

    // entered and left at a falling edge; valid is dropped once the request is taken
    task automatic send_pixel(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r,
                              input logic fe);
        int gap;
        if ($urandom_range(0, 31) == 0)
            src_burst = ~src_burst;
        gap = pick_gap(src_burst);
        if (gap > 0)
        begin
            pixel.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel.valid = 1'b1;
        pixel.column = c;
        pixel.row = r;
        pixel.frame_end = fe;
        @(posedge clk);
        while (!pixel.ready)
            @(posedge clk);
        @(negedge clk);
        pixel.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : sink
        int gap;
        color.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                dst_burst = ~dst_burst;
            gap = pick_gap(dst_burst);
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0)
            begin
                color.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            color.ready = 1'b1;
            @(posedge clk);
            while (!color.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int dcol [22] = '{0, 5, 1023, 160, 160, 160, 0, 1023, 1023, 160, 230, 319,
                          0, 512, 160, 160, 160, 160, 160, 160, 400, 90};
        int drow [22] = '{0, 31, 119, 126, 127, 1023, 1023, 1023, 127, 200, 200, 160,
                          140, 300, 130, 130, 130, 130, 200, 200, 250, 128};
        int dfe  [22] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0,
                          0, 1, 1, 1, 1, 1, 0, 1, 0, 0};
        int phase;
        int sent;
        int len;
        int kind;
        logic paused;
        logic frame_line;
        logic [COORD_W-1:0] c;
        logic [COORD_W-1:0] r;

        pixel.valid = 1'b0;
        pixel.column = '0;
        pixel.row = '0;
        pixel.frame_end = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_HORIZON_ROW;
        cfg.data = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait (pending == 0);
            @(negedge clk);
            case (phase)
                0: ;
                1:
                begin
                    horizon_now = 10'd0;
                    write_reg(CFG_HORIZON_ROW, 10'd0);
                    write_reg(CFG_ROAD_HALF_WIDTH, 10'd0);
                    write_reg(CFG_TURN_LIMIT, 10'd0);
                    write_reg(CFG_FORWARD_STEP, 10'd0);
                    write_reg(CFG_LATERAL_POSITION, 10'h200);
                end
                2:
                begin
                    horizon_now = 10'd880;
                    write_reg(CFG_HORIZON_ROW, horizon_now);
                    write_reg(CFG_ROAD_HALF_WIDTH, 10'd1023);
                    write_reg(CFG_TURN_LIMIT, 10'd127);
                    write_reg(CFG_FORWARD_STEP, 10'd255);
                    write_reg(CFG_LATERAL_POSITION, 10'h1FF);
                end
                default:
                begin
                    horizon_now = (phase == 3) ? 10'd1023 : 10'($urandom_range(40, 300));
                    write_reg(CFG_HORIZON_ROW, horizon_now);
                    write_reg(CFG_LATERAL_POSITION + 3'($urandom_range(1, 3)), 10'($urandom));
                    write_reg(CFG_ROAD_HALF_WIDTH, 10'($urandom));
                    write_reg(CFG_TURN_LIMIT,
                              ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 12))
                                                          : 10'($urandom));
                    write_reg(CFG_FORWARD_STEP, 10'($urandom));
                    write_reg(CFG_LATERAL_POSITION,
                              ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 8) - 4)
                                                          : 10'($urandom));
                    write_reg(CFG_LATERAL_POSITION + 3'($urandom_range(1, 3)), 10'($urandom));
                end
            endcase
            cfg.valid = 1'b0;

            if (phase == 0)
                for (int i = 0; i < 22; i++)
                    send_pixel(10'(dcol[i]), 10'(drow[i]), dfe[i] != 0);

            if (phase == 4)
                hold_cycles = LONG_HOLD;

            sent = 0;
            paused = 1'b0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if (sent >= ITEMS_PER_PHASE / 2 && !paused)
                begin
                    wait (pending == 0);
                    @(negedge clk);
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    send_pixel(10'($urandom), 10'($urandom), $urandom_range(0, 7) == 0);
                    sent++;
                end
                else
                begin
                    // a run of neighboring pixels on one scan line
                    kind = $urandom_range(0, 19);
                    if (kind < 15)
                        r = horizon_now + 10'($urandom_range(7, 150));
                    else if (kind < 17)
                        r = horizon_now - 10'($urandom_range(0, 20)) + 10'd6;
                    else
                        r = 10'($urandom);
                    c = ($urandom_range(0, 5) == 0) ? 10'($urandom)
                                                   : 10'($urandom_range(0, SCREEN_WIDTH - 1));
                    len = $urandom_range(1, 16);
                    frame_line = 1'($urandom_range(0, 1));
                    for (int k = 0; k < len; k++)
                        send_pixel(c + 10'(k), r, frame_line && (k == len - 1));
                    sent += len;
                end
            end
        end

        pixel.valid = 1'b0;
        wait (pending == 0);
        repeat (2 * LATENCY) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* pseudo_3d_road_pixel_generator.f */
design/p3drpg_pkg.sv
design/p3drpg_if.sv
design/p3drpg_ctrl.sv
design/p3drpg_dp.sv
design/pseudo_3d_road_pixel_generator.sv
design/p3drpg_checker.sv
tb/sv/p3drpg_road_checker.sv
tb/sv/pseudo_3d_road_pixel_generator_tb.sv
